// File: design/cfd_pkg.sv
// Shared types and constants for the contiguous file directory.
package cfd_pkg;

    localparam int SLOTS = 72;
    localparam int DEPTH = SLOTS + 1;
    localparam int IDX_W = $clog2(SLOTS + 1);
    localparam int CNT_W = $clog2(SLOTS + 2);

    localparam logic [IDX_W-1:0] SLOTS_IDX = IDX_W'(SLOTS);
    localparam logic [15:0] FDB_RESET = 16'd14;

    localparam logic [2:0] MODE_LOOKUP  = 3'd0;
    localparam logic [2:0] MODE_ADD     = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_COMPACT = 3'd3;
    localparam logic [2:0] MODE_READ    = 3'd4;
    localparam logic [2:0] MODE_WRITE   = 3'd5;

    typedef enum logic [1:0] {
        K_TEMP  = 2'd0,
        K_EMPTY = 2'd1,
        K_FILE  = 2'd2,
        K_END   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOTFOUND = 3'd1,
        ST_TOOBIG   = 3'd2,
        ST_NOSPACE  = 3'd3,
        ST_FULL     = 3'd4,
        ST_BADINDEX = 3'd5
    } status_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_F_RD,
        S_F_EV,
        S_F_DEC,
        S_A_RD,
        S_A_WR,
        S_A_LAST,
        S_C_CHK,
        S_C_RD2,
        S_C_EV,
        S_C_SRD,
        S_C_SWR,
        S_R_RD,
        S_R_EV,
        S_E_RD,
        S_E_EV,
        S_E_GET,
        S_DONE
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] name0;
        logic [15:0] name1;
        logic [15:0] name2;
        logic [15:0] length;
        logic [14:0] date;
    } slot_t;

    typedef struct packed {
        logic [2:0]  mode;
        logic [15:0] name0;
        logic [15:0] name1;
        logic [15:0] name2;
        logic [15:0] size;
        logic [14:0] date;
        logic [6:0]  eidx;
        kind_t       kind;
        logic [15:0] length;
    } request_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] start;
        slot_t       rec;
        logic [6:0]  free;
    } result_t;

    localparam slot_t SLOT0_RESET = '{K_EMPTY, 16'd0, 16'd0, 16'd0, 16'd494, 15'd0};
    localparam slot_t SLOT_RESET  = '{K_END, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0};

endpackage

// File: design/cfd_alu.sv
// Shared 16-bit add/subtract unit for start sums, merges and splits.
module cfd_alu (
    input  cfd_pkg::alu_op_t op,
    input  logic [15:0]      a,
    input  logic [15:0]      b,
    output logic [15:0]      y
);
    import cfd_pkg::*;

    always_comb
    begin
        unique case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

// File: design/cfd_store.sv
// Directory slot memory with per-slot valid bits standing in for the reset image.
module cfd_store (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      we,
    input  logic [cfd_pkg::IDX_W-1:0] waddr,
    input  cfd_pkg::slot_t            wdata,
    input  logic [cfd_pkg::IDX_W-1:0] raddr,
    output cfd_pkg::slot_t            rdata
);
    import cfd_pkg::*;

    slot_t            slot_mem [0:DEPTH-1];
    logic [DEPTH-1:0] vld_reg;
    slot_t            rd_reg;
    logic             rd_vld_reg;
    logic             rd_zero_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            slot_mem[waddr] <= wdata;
        end
        rd_reg <= slot_mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            rd_zero_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rd_vld_reg  <= vld_reg[raddr];
            rd_zero_reg <= (raddr == '0);
        end
    end

    // never-written slots read as their reset contents
    assign rdata = rd_vld_reg ? rd_reg : (rd_zero_reg ? SLOT0_RESET : SLOT_RESET);

endmodule

// File: design/cfd_ctrl.sv
// Request sequencer: slot scans, shifts, merges and end-marker rescans.
module cfd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  cfd_pkg::request_t req,
    input  logic [15:0]       first_data_block,
    output logic              idle,
    output logic              res_valid,
    input  logic              res_ready,
    output cfd_pkg::result_t  res
);
    import cfd_pkg::*;

    state_t            state_reg, state_next;
    request_t          req_reg, req_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [15:0]       acc_reg, acc_next;
    logic              hit_reg, hit_next;
    logic              fit_reg, fit_next;
    logic [IDX_W-1:0]  fidx_reg, fidx_next;
    slot_t             fit_rec_reg, fit_rec_next;
    logic [15:0]       fit_start_reg, fit_start_next;
    logic [IDX_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  cend_reg, cend_next;
    logic [IDX_W-1:0]  end_slot_reg, end_slot_next;
    slot_t             rec_a_reg, rec_a_next;
    status_t           status_reg, status_next;
    logic [15:0]       start_reg, start_next;
    slot_t             rec_reg, rec_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    slot_t             mem_wdata;
    logic [IDX_W-1:0]  mem_raddr;
    slot_t             rdata;
    alu_op_t           alu_op;
    logic [15:0]       alu_a;
    logic [15:0]       alu_b;
    logic [15:0]       alu_y;
    slot_t             file_rec;
    slot_t             wr_rec;
    logic              name_eq;

    cfd_store u_store (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    cfd_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    assign file_rec = '{K_FILE, req_reg.name0, req_reg.name1, req_reg.name2,
                        req_reg.size, req_reg.date};
    assign wr_rec   = '{req_reg.kind, req_reg.name0, req_reg.name1, req_reg.name2,
                        req_reg.length, req_reg.date};
    assign name_eq  = (rdata.name0 == req_reg.name0) && (rdata.name1 == req_reg.name1)
                      && (rdata.name2 == req_reg.name2);

    assign res = '{status_reg, start_reg, rec_reg,
                   7'(int'(SLOTS) - int'(end_slot_reg))};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            end_slot_reg <= IDX_W'(1);
            hit_reg      <= 1'b0;
            fit_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            end_slot_reg <= end_slot_next;
            hit_reg      <= hit_next;
            fit_reg      <= fit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        i_reg         <= i_next;
        acc_reg       <= acc_next;
        fidx_reg      <= fidx_next;
        fit_rec_reg   <= fit_rec_next;
        fit_start_reg <= fit_start_next;
        w_reg         <= w_next;
        cend_reg      <= cend_next;
        rec_a_reg     <= rec_a_next;
        status_reg    <= status_next;
        start_reg     <= start_next;
        rec_reg       <= rec_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        req_next       = req_reg;
        i_next         = i_reg;
        acc_next       = acc_reg;
        hit_next       = hit_reg;
        fit_next       = fit_reg;
        fidx_next      = fidx_reg;
        fit_rec_next   = fit_rec_reg;
        fit_start_next = fit_start_reg;
        w_next         = w_reg;
        cend_next      = cend_reg;
        end_slot_next  = end_slot_reg;
        rec_a_next     = rec_a_reg;
        status_next    = status_reg;
        start_next     = start_reg;
        rec_next       = rec_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = rdata;
        mem_raddr      = '0;
        alu_op         = ALU_ADD;
        alu_a          = acc_reg;
        alu_b          = rdata.length;
        idle           = 1'b0;
        res_valid      = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (req_valid)
                begin
                    req_next    = req;
                    i_next      = '0;
                    acc_next    = first_data_block;
                    hit_next    = 1'b0;
                    fit_next    = 1'b0;
                    status_next = ST_OK;
                    start_next  = '0;
                    rec_next    = '0;
                    unique case (req.mode)
                        MODE_LOOKUP, MODE_ADD, MODE_DELETE:
                        begin
                            state_next = S_F_RD;
                        end
                        MODE_COMPACT:
                        begin
                            cend_next  = CNT_W'(end_slot_reg) + 1'b1;
                            state_next = S_C_CHK;
                        end
                        MODE_READ, MODE_WRITE:
                        begin
                            if (int'(req.eidx) > SLOTS)
                            begin
                                status_next = ST_BADINDEX;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_E_RD;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BADINDEX;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end

            // name search, also noting the first empty extent that fits (add mode)
            S_F_RD:
            begin
                if (int'(i_reg) > SLOTS)
                begin
                    state_next = S_F_DEC;
                end
                else
                begin
                    mem_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_F_EV;
                end
            end

            S_F_EV:
            begin
                if (rdata.kind == K_END)
                begin
                    state_next = S_F_DEC;
                end
                else if ((rdata.kind == K_TEMP || rdata.kind == K_FILE) && name_eq)
                begin
                    hit_next       = 1'b1;
                    fidx_next      = i_reg[IDX_W-1:0];
                    fit_rec_next   = rdata;
                    fit_start_next = acc_reg;
                    state_next     = S_F_DEC;
                end
                else
                begin
                    if (req_reg.mode == MODE_ADD && !fit_reg && rdata.kind == K_EMPTY
                        && req_reg.size <= rdata.length)
                    begin
                        fit_next       = 1'b1;
                        fidx_next      = i_reg[IDX_W-1:0];
                        fit_rec_next   = rdata;
                        fit_start_next = acc_reg;
                    end
                    acc_next   = alu_y;
                    i_next     = i_reg + 1'b1;
                    state_next = S_F_RD;
                end
            end

            S_F_DEC:
            begin
                state_next = S_DONE;
                start_next = fit_start_reg;
                if (hit_reg)
                begin
                    rec_next = fit_rec_reg;
                    if (req_reg.mode == MODE_ADD && req_reg.size > fit_rec_reg.length)
                    begin
                        status_next = ST_TOOBIG;
                        start_next  = '0;
                        rec_next    = '0;
                    end
                    else if (req_reg.mode == MODE_DELETE)
                    begin
                        rec_next  = '{K_EMPTY, 16'd0, 16'd0, 16'd0, fit_rec_reg.length, 15'd0};
                        mem_we    = 1'b1;
                        mem_waddr = fidx_reg;
                        mem_wdata = '{K_EMPTY, 16'd0, 16'd0, 16'd0, fit_rec_reg.length,
                                      15'd0};
                    end
                end
                else if (req_reg.mode != MODE_ADD)
                begin
                    status_next = ST_NOTFOUND;
                    start_next  = '0;
                end
                else if (!fit_reg)
                begin
                    status_next = ST_NOSPACE;
                    start_next  = '0;
                end
                else if (fit_rec_reg.length == req_reg.size)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = fidx_reg;
                    mem_wdata = file_rec;
                    rec_next  = file_rec;
                end
                else if (end_slot_reg >= SLOTS_IDX || fidx_reg >= end_slot_reg)
                begin
                    status_next = ST_FULL;
                    start_next  = '0;
                end
                else
                begin
                    w_next     = end_slot_reg + 1'b1;
                    state_next = S_A_RD;
                end
            end

            // shift entries up one slot, top down, then split the extent
            S_A_RD:
            begin
                if (w_reg == fidx_reg + 1'b1)
                begin
                    alu_op     = ALU_SUB;
                    alu_a      = fit_rec_reg.length;
                    alu_b      = req_reg.size;
                    mem_we     = 1'b1;
                    mem_waddr  = w_reg;
                    mem_wdata  = fit_rec_reg;
                    mem_wdata.length = alu_y;
                    state_next = S_A_LAST;
                end
                else
                begin
                    mem_raddr  = w_reg - 1'b1;
                    state_next = S_A_WR;
                end
            end

            S_A_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = w_reg;
                mem_wdata  = rdata;
                w_next     = w_reg - 1'b1;
                state_next = S_A_RD;
            end

            S_A_LAST:
            begin
                mem_we        = 1'b1;
                mem_waddr     = fidx_reg;
                mem_wdata     = file_rec;
                end_slot_next = end_slot_reg + 1'b1;
                rec_next      = file_rec;
                state_next    = S_DONE;
            end

            // merge neighboring empties; cend_reg holds the working end slot plus one
            S_C_CHK:
            begin
                if (!(i_reg < cend_reg && int'(i_reg) <= SLOTS))
                begin
                    i_next     = '0;
                    state_next = S_R_RD;
                end
                else if (int'(i_reg) == SLOTS)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    mem_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_C_RD2;
                end
            end

            S_C_RD2:
            begin
                rec_a_next = rdata;
                mem_raddr  = i_reg[IDX_W-1:0] + 1'b1;
                state_next = S_C_EV;
            end

            S_C_EV:
            begin
                if (rec_a_reg.kind == K_EMPTY && rdata.kind == K_EMPTY)
                begin
                    alu_a      = rdata.length;
                    alu_b      = rec_a_reg.length;
                    mem_we     = 1'b1;
                    mem_waddr  = i_reg[IDX_W-1:0] + 1'b1;
                    mem_wdata  = rdata;
                    mem_wdata.length = alu_y;
                    w_next     = i_reg[IDX_W-1:0];
                    state_next = S_C_SRD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_C_CHK;
                end
            end

            S_C_SRD:
            begin
                if ((CNT_W'(w_reg) + 1'b1 < cend_reg) && (w_reg < SLOTS_IDX))
                begin
                    mem_raddr  = w_reg + 1'b1;
                    state_next = S_C_SWR;
                end
                else
                begin
                    cend_next  = cend_reg - 1'b1;
                    state_next = S_C_CHK;
                end
            end

            S_C_SWR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = w_reg;
                mem_wdata  = rdata;
                w_next     = w_reg + 1'b1;
                state_next = S_C_SRD;
            end

            // find the first end marker
            S_R_RD:
            begin
                if (int'(i_reg) > SLOTS)
                begin
                    end_slot_next = SLOTS_IDX;
                    state_next    = S_DONE;
                end
                else
                begin
                    mem_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_R_EV;
                end
            end

            S_R_EV:
            begin
                if (rdata.kind == K_END)
                begin
                    end_slot_next = i_reg[IDX_W-1:0];
                    state_next    = S_DONE;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_R_RD;
                end
            end

            // sum lengths ahead of the indexed entry, then read or write it
            S_E_RD:
            begin
                if (int'(i_reg) == int'(req_reg.eidx))
                begin
                    if (req_reg.mode == MODE_READ)
                    begin
                        mem_raddr  = IDX_W'(req_reg.eidx);
                        state_next = S_E_GET;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = IDX_W'(req_reg.eidx);
                        mem_wdata  = wr_rec;
                        rec_next   = wr_rec;
                        start_next = acc_reg;
                        i_next     = '0;
                        state_next = S_R_RD;
                    end
                end
                else
                begin
                    mem_raddr  = i_reg[IDX_W-1:0];
                    state_next = S_E_EV;
                end
            end

            S_E_EV:
            begin
                acc_next   = alu_y;
                i_next     = i_reg + 1'b1;
                state_next = S_E_RD;
            end

            S_E_GET:
            begin
                rec_next   = rdata;
                start_next = acc_reg;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: design/contiguous_file_directory_core.sv
// Top level of the contiguous file directory: handshakes, config register, result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request transaction: mode, name words,
//   size, date, entry index, kind and length. A transaction is taken when in_valid is high
//   and in_stall is low. in_stall stays high while a request is being worked on.
//   Output channel (out_valid / out_stall) carries one result transaction per request.
//   The result sits in an output register, so a stalled receiver does not block the
//   start of the next request; the next result waits until the register is free.
//   Config channel (cfg_valid / cfg_ready) writes first_data_block; cfg_ready is always
//   high. Write it only while no request is outstanding.
// Sequencing (each directory slot is read and then evaluated, through a single read port):
//   lookup/delete: slots scanned one at a time up to the hit or end marker.
//   add with split: scan, then each entry above the split moved up one slot.
//   read entry: sums the slots ahead of the index; write entry adds a rescan
//   for the end marker (slot by slot up to it).
//   compact: each merge shifts the tail down entry by entry, then a rescan;
//   worst case grows with merges times tail length.
// Reset: directory holds one empty extent of 494 blocks in slot 0, the rest end markers,
//   first_data_block is 14. No clearing pass: per-slot valid bits give the reset image.
module contiguous_file_directory_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  mode,
    input  logic [15:0] name_word0,
    input  logic [15:0] name_word1,
    input  logic [15:0] name_word2,
    input  logic [15:0] size_blocks,
    input  logic [14:0] date_in,
    input  logic [6:0]  entry_index,
    input  logic [1:0]  kind_in,
    input  logic [15:0] length_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [15:0] start_block,
    output logic [15:0] length_out,
    output logic [1:0]  kind_out,
    output logic [15:0] name_out0,
    output logic [15:0] name_out1,
    output logic [15:0] name_out2,
    output logic [14:0] date_out,
    output logic [6:0]  free_slots,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import cfd_pkg::*;

    logic        idle;
    logic        res_valid;
    logic        res_ready;
    request_t    req;
    result_t     res;
    logic [15:0] fdb_reg;
    logic        out_valid_reg;
    result_t     out_reg;

    assign in_stall  = !idle;
    assign cfg_ready = 1'b1;

    assign req = '{mode, name_word0, name_word1, name_word2, size_blocks, date_in,
                   entry_index, kind_t'(kind_in), length_in};

    // result register frees when empty or being taken this cycle
    assign res_ready = !out_valid_reg || !out_stall;

    cfd_ctrl u_ctrl (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (in_valid && !in_stall),
        .req              (req),
        .first_data_block (fdb_reg),
        .idle             (idle),
        .res_valid        (res_valid),
        .res_ready        (res_ready),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fdb_reg       <= FDB_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                fdb_reg <= cfg_data;
            end
            if (res_ready)
            begin
                out_valid_reg <= res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_reg.status;
    assign start_block = out_reg.start;
    assign length_out  = out_reg.rec.length;
    assign kind_out    = out_reg.rec.kind;
    assign name_out0   = out_reg.rec.name0;
    assign name_out1   = out_reg.rec.name1;
    assign name_out2   = out_reg.rec.name2;
    assign date_out    = out_reg.rec.date;
    assign free_slots  = out_reg.free;

endmodule
